[rtl/spcq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spcq_pkg: shared types and constants for the strict priority call queue
// Field widths, operation and event codes, and the command word that travels
// from the front end to the scheduler core.
// ----------------------------------------------------------------------------
package spcq_pkg;

  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned ID_W        = 12;
  localparam int unsigned CLS_W       = 2;
  localparam int unsigned DUR_W       = 10;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned ENTRY_W     = ID_W + DUR_W;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_QUEUED        = 2'd0,
    EV_DROPPED       = 2'd1,
    EV_TICK_IDLE     = 2'd2,
    EV_TICK_ANSWERED = 2'd3
  } event_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [DUR_W-1:0]  dur;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : spcq_pkg
`default_nettype wire

[rtl/spcq_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spcq_front: input stage
// Registers each accepted input word and classifies it into a command word.
// Fields that a tick does not use are cleared here.
// ----------------------------------------------------------------------------
module spcq_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic                        operation_i,
  input  wire logic [spcq_pkg::ID_W-1:0]   caller_id_i,
  input  wire logic [spcq_pkg::CLS_W-1:0]  priority_class_i,
  input  wire logic [spcq_pkg::DUR_W-1:0]  call_duration_i,
  output      logic                        cmd_valid_o,
  input  wire logic                        cmd_ready_i,
  output      spcq_pkg::cmd_t              cmd_o
);

  logic           valid_q;
  spcq_pkg::cmd_t cmd_q;
  spcq_pkg::cmd_t cmd_d;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d.op = spcq_pkg::op_e'(operation_i);
    if (cmd_d.op == spcq_pkg::OP_TICK) begin
      cmd_d.id  = '0;
      cmd_d.cls = '0;
      cmd_d.dur = '0;
    end else begin
      cmd_d.id  = caller_id_i;
      cmd_d.cls = priority_class_i;
      cmd_d.dur = call_duration_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule : spcq_front
`default_nettype wire

[rtl/spcq_cmd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spcq_cmd_queue: two-entry command queue
// Decouples the front end from the scheduler core so that each side can
// stall without holding the other.
// ----------------------------------------------------------------------------
module spcq_cmd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output      logic            push_ready_o,
  input  wire spcq_pkg::cmd_t  push_data_i,
  output      logic            pop_valid_o,
  input  wire logic            pop_ready_i,
  output      spcq_pkg::cmd_t  pop_data_o,
  output      spcq_pkg::q_status_t status_o
);

  spcq_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic           pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign push_ready_o   = !status_o.full;
  assign pop_valid_o    = !status_o.empty;
  assign pop_data_o     = entry_q[rd_ptr_q];
  assign push           = push_valid_i && push_ready_o;
  assign pop            = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule : spcq_cmd_queue
`default_nettype wire

[rtl/spcq_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spcq_back: scheduler core
// Holds the four class FIFOs in one memory, the server countdown and the
// tick counter. Executes one command at a time into an output register.
// ----------------------------------------------------------------------------
module spcq_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  output      logic                         cmd_ready_o,
  input  wire spcq_pkg::cmd_t               cmd_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [1:0]                   event_kind_o,
  output      logic [spcq_pkg::ID_W-1:0]    answered_id_o,
  output      logic [spcq_pkg::CLS_W-1:0]   answered_class_o,
  output      logic [spcq_pkg::TICK_W-1:0]  tick_number_o
);

  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_N  = spcq_pkg::NUM_CLASSES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_N);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                          state_q;
  logic [CNT_W-1:0]                count_q [spcq_pkg::NUM_CLASSES];
  logic [IDX_W-1:0]                head_q  [spcq_pkg::NUM_CLASSES];
  logic [IDX_W-1:0]                tail_q  [spcq_pkg::NUM_CLASSES];
  logic [spcq_pkg::DUR_W-1:0]      busy_q;
  logic [spcq_pkg::TICK_W-1:0]     tick_q;
  logic [spcq_pkg::CLS_W-1:0]      pick_cls_q;

  logic                            out_valid_q;
  spcq_pkg::event_e                out_kind_q;
  logic [spcq_pkg::ID_W-1:0]       out_id_q;
  logic [spcq_pkg::CLS_W-1:0]      out_cls_q;
  logic [spcq_pkg::TICK_W-1:0]     out_tick_q;

  logic [spcq_pkg::ENTRY_W-1:0]    mem_q [MEM_N];
  logic [spcq_pkg::ENTRY_W-1:0]    rd_data_q;

  logic                            out_free;
  logic                            out_load;
  logic                            take;
  logic                            is_tick;
  logic                            full;
  logic                            any_pending;
  logic [spcq_pkg::CLS_W-1:0]      pick;
  logic                            wr_en;
  logic                            rd_en;
  logic [ADDR_W-1:0]               wr_addr;
  logic [ADDR_W-1:0]               rd_addr;
  logic [spcq_pkg::DUR_W-1:0]      rd_dur;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign is_tick     = (cmd_i.op == spcq_pkg::OP_TICK);
  assign full        = (count_q[cmd_i.cls] == CNT_W'(QUEUE_DEPTH));

  // Highest non-empty class wins.
  always_comb begin
    pick        = '0;
    any_pending = 1'b0;
    for (int c = 0; c < spcq_pkg::NUM_CLASSES; c++) begin
      if (count_q[c] != '0) begin
        pick        = spcq_pkg::CLS_W'(c);
        any_pending = 1'b1;
      end
    end
  end

  assign wr_en   = take && !is_tick && !full;
  assign rd_en   = take && is_tick && (busy_q == '0) && any_pending;
  assign wr_addr = ADDR_W'(cmd_i.cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[cmd_i.cls]);
  assign rd_addr = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[pick]);
  assign rd_dur  = rd_data_q[spcq_pkg::DUR_W-1:0];

  // A new result word enters the output register this cycle.
  assign out_load = ((state_q == ST_IDLE) && take && !rd_en) ||
                    ((state_q == ST_READ) && out_free);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {cmd_i.id, cmd_i.dur};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      tick_q      <= '0;
      pick_cls_q  <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= spcq_pkg::EV_QUEUED;
      out_id_q    <= '0;
      out_cls_q   <= '0;
      out_tick_q  <= '0;
      for (int c = 0; c < spcq_pkg::NUM_CLASSES; c++) begin
        count_q[c] <= '0;
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
      end
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (!is_tick) begin
              out_kind_q  <= full ? spcq_pkg::EV_DROPPED : spcq_pkg::EV_QUEUED;
              out_id_q    <= cmd_i.id;
              out_cls_q   <= cmd_i.cls;
              out_tick_q  <= tick_q;
              if (!full) begin
                tail_q[cmd_i.cls]  <= next_idx(tail_q[cmd_i.cls]);
                count_q[cmd_i.cls] <= count_q[cmd_i.cls] + CNT_W'(1);
              end
            end else if (rd_en) begin
              // Answer this tick once the entry comes back from memory.
              head_q[pick]  <= next_idx(head_q[pick]);
              count_q[pick] <= count_q[pick] - CNT_W'(1);
              pick_cls_q    <= pick;
              state_q       <= ST_READ;
            end else begin
              if (busy_q != '0) begin
                busy_q <= busy_q - spcq_pkg::DUR_W'(1);
              end
              tick_q      <= tick_q + spcq_pkg::TICK_W'(1);
              out_kind_q  <= spcq_pkg::EV_TICK_IDLE;
              out_id_q    <= '0;
              out_cls_q   <= '0;
              out_tick_q  <= tick_q + spcq_pkg::TICK_W'(1);
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            busy_q      <= (rd_dur == '0) ? '0 : rd_dur - spcq_pkg::DUR_W'(1);
            tick_q      <= tick_q + spcq_pkg::TICK_W'(1);
            out_kind_q  <= spcq_pkg::EV_TICK_ANSWERED;
            out_id_q    <= rd_data_q[spcq_pkg::ENTRY_W-1:spcq_pkg::DUR_W];
            out_cls_q   <= pick_cls_q;
            out_tick_q  <= tick_q + spcq_pkg::TICK_W'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_kind_q;
  assign answered_id_o    = out_id_q;
  assign answered_class_o = out_cls_q;
  assign tick_number_o    = out_tick_q;

endmodule : spcq_back
`default_nettype wire

[rtl/strict_priority_call_queue_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// strict_priority_call_queue_top: single-server strict priority scheduler
// Four FIFO classes (regular, silver, gold, platinum) feed one server.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per item. An
//   arrival word puts caller_id_i and call_duration_i at the back of the FIFO
//   named by priority_class_i, or is dropped when that FIFO is full. A tick
//   word closes the current tick: when the server is free it answers the
//   oldest caller of the highest non-empty class and stays busy for that
//   call's duration, then the tick counter advances.
//   Output channel (out_valid_o / out_ready_i) returns exactly one word per
//   input word, in order: the event kind, the caller and class involved,
//   and the tick count after the item.
// Pipeline and throughput:
//   A result word passes the front register, the command queue and the output
//   register; a tick that answers a call also passes the memory read register.
//   The core retires one word per cycle while the receiver takes its results,
//   except an answering tick, which waits on the registered class FIFO read port.
// Reset:
//   All FIFOs empty, server free, tick count zero. No clearing pass.
// Stalls:
//   While the receiver holds out_ready_i low, the front register and the
//   two-entry command queue still take up to three more words.
// ----------------------------------------------------------------------------
module strict_priority_call_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [spcq_pkg::ID_W-1:0]    caller_id_i,
  input  wire logic [spcq_pkg::CLS_W-1:0]   priority_class_i,
  input  wire logic [spcq_pkg::DUR_W-1:0]   call_duration_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [1:0]                   event_kind_o,
  output      logic [spcq_pkg::ID_W-1:0]    answered_id_o,
  output      logic [spcq_pkg::CLS_W-1:0]   answered_class_o,
  output      logic [spcq_pkg::TICK_W-1:0]  tick_number_o
);

  // Front end to command queue.
  logic                fr_valid;
  logic                fr_ready;
  spcq_pkg::cmd_t      fr_cmd;

  // Command queue to scheduler core.
  logic                bk_valid;
  logic                bk_ready;
  spcq_pkg::cmd_t      bk_cmd;
  spcq_pkg::q_status_t q_stat;

  spcq_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .caller_id_i      (caller_id_i),
    .priority_class_i (priority_class_i),
    .call_duration_i  (call_duration_i),
    .cmd_valid_o      (fr_valid),
    .cmd_ready_i      (fr_ready),
    .cmd_o            (fr_cmd)
  );

  spcq_cmd_queue u_cmd_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd),
    .status_o     (q_stat)
  );

  spcq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (bk_valid),
    .cmd_ready_o      (bk_ready),
    .cmd_i            (bk_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .answered_id_o    (answered_id_o),
    .answered_class_o (answered_class_o),
    .tick_number_o    (tick_number_o)
  );

  // An accepted word always lands in the front register.
  a_front_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> fr_valid)
    else $error("accepted word did not reach the front register");

  // The core only pulls commands that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_valid && bk_ready |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  // A tick without an answer reports no caller.
  a_idle_tick_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == spcq_pkg::EV_TICK_IDLE)
      |-> (answered_id_o == '0) && (answered_class_o == '0))
    else $error("idle tick carries a caller");

endmodule : strict_priority_call_queue_top
`default_nettype wire

[dv/strict_priority_call_queue_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_call_queue_top_tb: self-checking bench for the call queue
// A driver feeds arrival and tick words from a pending list, and a monitor
// predicts each accepted word's event and checks the result words in order.
// ----------------------------------------------------------------------------
module strict_priority_call_queue_top_tb;

  localparam int unsigned NUM_CLASSES  = spcq_pkg::NUM_CLASSES;
  localparam int unsigned ID_W         = spcq_pkg::ID_W;
  localparam int unsigned CLS_W        = spcq_pkg::CLS_W;
  localparam int unsigned DUR_W        = spcq_pkg::DUR_W;
  localparam int unsigned TICK_W       = spcq_pkg::TICK_W;
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_WORDS = 850;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT     = 26;
  // Both sides run without any idling inside this window of cycles.
  localparam int unsigned STEADY_FROM  = 300;
  localparam int unsigned STEADY_TO    = 700;

  // One caller waiting in a class queue of the predictor.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] dur;
  } waiting_call_t;

  // One predicted result word.
  typedef struct packed {
    spcq_pkg::event_e  kind;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [TICK_W-1:0] tick;
  } call_event_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  spcq_pkg::op_e     operation;
  logic [ID_W-1:0]   caller_id;
  logic [CLS_W-1:0]  priority_class;
  logic [DUR_W-1:0]  call_duration;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        event_kind;
  logic [ID_W-1:0]   answered_id;
  logic [CLS_W-1:0]  answered_class;
  logic [TICK_W-1:0] tick_number;

  spcq_pkg::cmd_t pending_words[$];
  call_event_t    expected_events[$];

  // Predictor state: one ring per class, the server countdown and the tick count.
  waiting_call_t     call_ring [NUM_CLASSES][QUEUE_DEPTH];
  int unsigned       ring_head [NUM_CLASSES];
  int unsigned       ring_fill [NUM_CLASSES];
  logic [DUR_W-1:0]  server_busy_ticks;
  logic [TICK_W-1:0] tick_counter;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned event_seen [4];
  logic        steady_phase;

  assign steady_phase = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

  strict_priority_call_queue_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .caller_id_i      (caller_id),
    .priority_class_i (priority_class),
    .call_duration_i  (call_duration),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_kind_o     (event_kind),
    .answered_id_o    (answered_id),
    .answered_class_o (answered_class),
    .tick_number_o    (tick_number)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Works out the result word for one accepted word and updates the
  // predictor. A tick answers at most one caller, highest class first, and
  // only when the server countdown has reached zero.
  function automatic void predict_call_event(spcq_pkg::cmd_t word);
    call_event_t   ev;
    waiting_call_t call;
    logic          found;
    int unsigned   slot;
    ev.id   = '0;
    ev.cls  = '0;
    ev.kind = spcq_pkg::EV_TICK_IDLE;
    found   = 1'b0;
    if (word.op == spcq_pkg::OP_ARRIVAL) begin
      ev.id  = word.id;
      ev.cls = word.cls;
      if (ring_fill[word.cls] >= QUEUE_DEPTH) begin
        ev.kind = spcq_pkg::EV_DROPPED;
      end else begin
        slot = (ring_head[word.cls] + ring_fill[word.cls]) % QUEUE_DEPTH;
        call.id  = word.id;
        call.dur = word.dur;
        call_ring[word.cls][slot] = call;
        ring_fill[word.cls]++;
        ev.kind = spcq_pkg::EV_QUEUED;
      end
    end else begin
      if (server_busy_ticks == '0) begin
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
          if (!found && ring_fill[c] != 0) begin
            call = call_ring[c][ring_head[c]];
            ring_head[c] = (ring_head[c] + 1) % QUEUE_DEPTH;
            ring_fill[c]--;
            ev.id   = call.id;
            ev.cls  = CLS_W'(c);
            ev.kind = spcq_pkg::EV_TICK_ANSWERED;
            server_busy_ticks = call.dur;
            found = 1'b1;
          end
        end
      end
      if (server_busy_ticks != '0) server_busy_ticks--;
      tick_counter++;
    end
    ev.tick = tick_counter;
    expected_events.push_back(ev);
  endfunction

  function automatic void add_word(spcq_pkg::op_e op, logic [ID_W-1:0] id,
                                   logic [CLS_W-1:0] cls, logic [DUR_W-1:0] dur);
    spcq_pkg::cmd_t word;
    word.op  = op;
    word.id  = id;
    word.cls = cls;
    word.dur = dur;
    pending_words.push_back(word);
  endfunction

  // Short service times keep the server turning over; a few longer ones
  // let the queues build up behind a busy server.
  function automatic logic [DUR_W-1:0] pick_duration();
    if ($urandom_range(99) < 85) return DUR_W'($urandom_range(2));
    return DUR_W'($urandom_range(12, 3));
  endfunction

  // Driver: a word stays on the bus until it is taken. A new word is offered
  // only once the previous one is gone, and the bus idles at random outside
  // the steady window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid       <= 1'b0;
      operation      <= spcq_pkg::OP_ARRIVAL;
      caller_id      <= '0;
      priority_class <= '0;
      call_duration  <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && (steady_phase || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid       <= 1'b1;
        operation      <= pending_words[0].op;
        caller_id      <= pending_words[0].id;
        priority_class <= pending_words[0].cls;
        call_duration  <= pending_words[0].dur;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side: stalls at random outside the steady window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      cycle_count <= 0;
    end else begin
      out_ready   <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
      cycle_count <= cycle_count + 1;
    end
  end

  // Monitor: the prediction is made at the edge where the word is taken, and
  // each result word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    call_event_t exp_ev;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict_call_event(spcq_pkg::cmd_t'({operation, caller_id, priority_class,
                                             call_duration}));
      end
      if (out_valid && out_ready) begin
        event_seen[event_kind]++;
        if (expected_events.size() == 0) begin
          $error("unexpected result word: event_kind %0d, answered_id %0d", event_kind,
                 answered_id);
          mismatch_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          if (event_kind !== exp_ev.kind) begin
            $error("event_kind: expected %0d, got %0d", exp_ev.kind, event_kind);
            mismatch_count++;
          end
          if (answered_id !== exp_ev.id) begin
            $error("answered_id: expected %0d, got %0d", exp_ev.id, answered_id);
            mismatch_count++;
          end
          if (answered_class !== exp_ev.cls) begin
            $error("answered_class: expected %0d, got %0d", exp_ev.cls, answered_class);
            mismatch_count++;
          end
          if (tick_number !== exp_ev.tick) begin
            $error("tick_number: expected %0d, got %0d", exp_ev.tick, tick_number);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned n_arrivals;
    logic [CLS_W-1:0] burst_cls;
    logic burst;

    rst_ni            = 1'b0;
    mismatch_count    = 0;
    server_busy_ticks = '0;
    tick_counter      = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      ring_head[c] = 0;
      ring_fill[c] = 0;
    end
    for (int k = 0; k < 4; k++) event_seen[k] = 0;

    // Directed opening. A tick on an empty scheduler, with every unused
    // field at its top value, must answer nobody.
    add_word(spcq_pkg::OP_TICK, 12'hFFF, 2'd3, 10'h3FF);
    // One caller in each of the upper three classes.
    add_word(spcq_pkg::OP_ARRIVAL, 12'hFFF, 2'd3, 10'd0);
    add_word(spcq_pkg::OP_ARRIVAL, 12'hAAA, 2'd2, 10'd2);
    add_word(spcq_pkg::OP_ARRIVAL, 12'h555, 2'd1, 10'd1);
    // Fill the regular queue to the brim, then one more arrival that must be
    // dropped and echoed back with its id and class.
    add_word(spcq_pkg::OP_ARRIVAL, 12'h000, 2'd0, 10'd0);
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      add_word(spcq_pkg::OP_ARRIVAL, ID_W'(k), 2'd0, 10'd0);
    end
    add_word(spcq_pkg::OP_ARRIVAL, 12'hFFF, 2'd0, 10'h3FF);
    // Platinum goes first with zero duration, so gold is answered on the
    // very next tick. Gold holds the server for one idle tick, then silver
    // and finally regular get their turn.
    repeat (5) add_word(spcq_pkg::OP_TICK, 12'h000, 2'd0, 10'd0);

    // Random part: ticks with a handful of arrivals in front of them, now and
    // then a burst into one class that can overflow it, and now and then a run
    // of bare ticks that lets the queues drain. Tick words carry random junk in
    // the fields they ignore.
    while (pending_words.size() < RANDOM_WORDS) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(15, 5)) begin
          add_word(spcq_pkg::OP_TICK, ID_W'($urandom), CLS_W'($urandom), DUR_W'($urandom));
        end
      end else begin
        burst      = ($urandom_range(99) < 6);
        burst_cls  = CLS_W'($urandom_range(3));
        n_arrivals = burst ? $urandom_range(20, 12) : $urandom_range(2);
        repeat (n_arrivals) begin
          add_word(spcq_pkg::OP_ARRIVAL, ID_W'($urandom),
                   burst ? burst_cls : CLS_W'($urandom_range(3)), pick_duration());
        end
        add_word(spcq_pkg::OP_TICK, ID_W'($urandom), CLS_W'($urandom), DUR_W'($urandom));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every word has been taken and every result has come back,
    // then give the core a few more cycles to show any stray result word.
    while (pending_words.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d ticks: %0d answered, %0d idle.",
             event_seen[spcq_pkg::EV_TICK_ANSWERED] + event_seen[spcq_pkg::EV_TICK_IDLE],
             event_seen[spcq_pkg::EV_TICK_ANSWERED], event_seen[spcq_pkg::EV_TICK_IDLE]);
    $display("Arrivals: %0d queued, %0d dropped on a full class; %0d mismatches.",
             event_seen[spcq_pkg::EV_QUEUED], event_seen[spcq_pkg::EV_DROPPED],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/spcq_pkg.sv
rtl/spcq_front.sv
rtl/spcq_cmd_queue.sv
rtl/spcq_back.sv
rtl/strict_priority_call_queue_top.sv
dv/strict_priority_call_queue_top_tb.sv
